// File: sv/gpdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpdu_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF   = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field and datapath widths
  localparam int PROB_W      = 32;  // widest probability field
  localparam int NUM_W       = 34;  // 2*r0 + r1 at the widest field
  localparam int ACC_W       = 40;  // unpack accumulator
  localparam int BITS_W      = 6;   // bit count / field width
  localparam int COUNT_W     = 13;  // sample_count register
  localparam int IDX_W       = 12;  // sample_index output
  localparam int DOSAGE_W    = 19;  // dosage output
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_BITS_PER_PROB = 2'd0;
  localparam logic [1:0] REG_PHASED_MODE   = 2'd1;
  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd2;

  // Register reset values
  localparam logic [BITS_W-1:0]  BITS_PER_PROB_RST = 6'd8;
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST  = 13'd1;

  // Input beat kinds (tuser)
  localparam logic ACT_STATUS = 1'b0;
  localparam logic ACT_PROB   = 1'b1;

  // Status byte decode
  localparam int         MISSING_BIT    = 7;
  localparam logic [5:0] PLOIDY_DIPLOID = 6'd2;

endpackage

`default_nettype wire

// File: sv/gpdu_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// quot = (num * 2^(FRACTION_BITS+1) + d) / (2*d), num/d with FRACTION_BITS fraction bits, rounded to nearest.
module gpdu_div #(
  parameter int FRACTION_BITS = gpdu_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [gpdu_pkg::NUM_W-1:0]      num,
  input  logic [gpdu_pkg::PROB_W-1:0]     dval,
  output logic                            done,
  output logic [FRACTION_BITS+2:0]        quot
);

  localparam int QW   = FRACTION_BITS + 3;
  localparam int NW   = gpdu_pkg::NUM_W + FRACTION_BITS + 1;
  localparam int RW   = gpdu_pkg::PROB_W + 1;
  localparam int CNTW = $clog2(QW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   two_d;
  logic [QW-1:0]   lo;
  logic [NW-1:0]   dividend;
  logic [RW:0]     trial;
  logic [RW-1:0]   rem_sub;
  logic            ge;

  // Rounded dividend; remainder stays below 2d from the first step on
  assign dividend = (NW'(num) << (FRACTION_BITS + 1)) + NW'(dval);

  // One trial subtraction per cycle
  assign trial   = {rem, lo[QW-1]};
  assign ge      = trial >= {1'b0, two_d};
  assign rem_sub = RW'(trial - {1'b0, two_d});

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= RW'(dividend[NW-1:QW]);
      lo    <= dividend[QW-1:0];
      two_d <= {dval, 1'b0};
    end else if (busy) begin
      rem  <= ge ? rem_sub : trial[RW-1:0];
      lo   <= lo << 1;
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: sv/genotype_probability_dosage_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

// Layout-2 genotype probability decoder for biallelic diploid samples. Feed one
// status byte per sample first (tuser = 0), then the probability bitstream bytes
// (tuser = 1); each completed pair of B-bit fields within the sample count gives
// one beat with the sample index, the ALT dosage in signed fixed point
// (FRACTION_BITS fraction bits, rounded to nearest), and missing / bad-ploidy
// flags; tlast marks the final result of an input byte. Statuses live in a
// synchronous RAM of MAX_SAMPLES x 2 bits with one write and one read port and
// no clearing pass. Items are handled one at a time: a status byte is written
// in idle; a bitstream byte is taken in idle, its fields are extracted, and each
// pair is read for status, divided by the one-bit-per-cycle divider, then the
// next pair is sought before the result is emitted. A finished result waits in the
// output register while the next byte is taken. Configure only while idle.
module genotype_probability_dosage_unpack #(
  parameter int MAX_SAMPLES   = gpdu_pkg::MAX_SAMPLES_DEF,
  parameter int FRACTION_BITS = gpdu_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input beats
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gpdu_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte, [8] restart
  input  logic [0:0]                          s_tuser,   // [0] action
  // result beats
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gpdu_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [11:0] sample_index,
                                                         // [30:12] dosage, [31] missing,
                                                         // [32] bad_ploidy
  output logic                                m_tlast,   // last
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gpdu_pkg::PADDR_W-1:0]        paddr,
  input  logic [gpdu_pkg::PDATA_W-1:0]        pwdata,
  output logic [gpdu_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int QW = FRACTION_BITS + 3;
  localparam int VW = FRACTION_BITS + 4;
  localparam logic [VW-1:0] TWO_FIX = VW'(2) << FRACTION_BITS;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXTRACT = 6'b000010,
    S_READ    = 6'b000100,
    S_DIV     = 6'b001000,
    S_SEEK    = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [gpdu_pkg::BITS_W-1:0]  bits_per_prob;
  logic                         phased_mode;
  logic [gpdu_pkg::COUNT_W-1:0] sample_count;

  // unpacker and counters
  logic [CW-1:0]                status_write_index;
  logic [gpdu_pkg::ACC_W-1:0]   acc;
  logic [gpdu_pkg::BITS_W-1:0]  acc_bits;
  logic [gpdu_pkg::PROB_W-1:0]  first_held;
  logic                         have_first;
  logic [CW-1:0]                next_sample;
  logic                         more;

  // pair in flight and finished result
  logic [gpdu_pkg::PROB_W-1:0]  r0, r1;
  logic [CW-1:0]                pair_idx;
  logic [1:0]                   st_q;
  logic [gpdu_pkg::IDX_W-1:0]   res_idx;
  logic [gpdu_pkg::DOSAGE_W-1:0] res_dos;
  logic                         res_miss, res_bad;

  // status RAM
  logic [1:0]                   status_mem [MAX_SAMPLES];
  logic [1:0]                   rd_data;
  logic [AW-1:0]                rd_addr;
  logic                         st_wr_en;
  logic [CW-1:0]                swi_eff;
  logic [1:0]                   st_wr_data;

  // decoded inputs and datapath
  logic                         in_accept, in_action, in_restart;
  logic [7:0]                   in_byte;
  logic                         cfg_wr, out_free;
  logic [1:0]                   cfg_idx;
  logic [gpdu_pkg::BITS_W-1:0]  eff_b;
  logic [gpdu_pkg::PROB_W-1:0]  fmask, field;
  logic                         field_ok, pair_ok, take_pair;
  logic [CW-1:0]                limit;
  logic [gpdu_pkg::NUM_W-1:0]   num;
  logic                         div_start, div_done;
  logic [QW-1:0]                quot;
  logic [VW-1:0]                dos_v;
  logic [gpdu_pkg::DOSAGE_W-1:0] dosage_val;

  assign in_accept  = s_tvalid & s_tready;
  assign in_action  = s_tuser[0];
  assign in_byte    = s_tdata[7:0];
  assign in_restart = s_tdata[8];
  assign s_tready   = (state == S_IDLE);

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];
  assign out_free = ~m_tvalid | m_tready;

  // Effective field width, clamped to 1..32
  always_comb begin
    if (bits_per_prob == '0) begin
      eff_b = gpdu_pkg::BITS_W'(1);
    end else if (bits_per_prob > gpdu_pkg::BITS_W'(gpdu_pkg::PROB_W)) begin
      eff_b = gpdu_pkg::BITS_W'(gpdu_pkg::PROB_W);
    end else begin
      eff_b = bits_per_prob;
    end
  end

  // d = 2^B - 1 doubles as the field mask
  assign fmask = gpdu_pkg::PROB_W'((33'd1 << eff_b) - 33'd1);
  assign field = acc[gpdu_pkg::PROB_W-1:0] & fmask;

  // Sample limit = min(sample_count, MAX_SAMPLES)
  always_comb begin
    if (32'(sample_count) < 32'(MAX_SAMPLES)) begin
      limit = CW'(sample_count);
    end else begin
      limit = CW'(MAX_SAMPLES);
    end
  end

  assign field_ok  = acc_bits >= eff_b;
  assign pair_ok   = next_sample < limit;
  assign take_pair = field_ok & have_first & pair_ok;

  // Status write on a status beat
  assign swi_eff    = in_restart ? '0 : status_write_index;
  assign st_wr_en   = in_accept && (in_action == gpdu_pkg::ACT_STATUS) &&
                      (swi_eff != CW'(MAX_SAMPLES));
  assign st_wr_data = {in_byte[5:0] != gpdu_pkg::PLOIDY_DIPLOID,
                       in_byte[gpdu_pkg::MISSING_BIT]};

  // Writes only in idle; the read data is used only while a pair runs
  assign rd_addr = (state == S_EMIT) ? pair_idx[AW-1:0] : next_sample[AW-1:0];

  always_ff @(posedge clk) begin
    if (st_wr_en) begin
      status_mem[swi_eff[AW-1:0]] <= st_wr_data;
    end
    rd_data <= status_mem[rd_addr];
  end

  // Dosage numerator
  assign num = phased_mode ? gpdu_pkg::NUM_W'(r0) + gpdu_pkg::NUM_W'(r1)
                           : gpdu_pkg::NUM_W'({r0, 1'b0}) + gpdu_pkg::NUM_W'(r1);

  assign div_start = (state == S_READ);

  gpdu_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .dval  (fmask),
    .done  (div_done),
    .quot  (quot)
  );

  // 2.0 - quotient, resized as a signed value to the output width
  assign dos_v      = TWO_FIX - VW'(quot);
  assign dosage_val = gpdu_pkg::DOSAGE_W'(signed'(dos_v));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE: begin
        if (in_accept && (in_action == gpdu_pkg::ACT_PROB)) state_next = S_EXTRACT;
      end
      S_EXTRACT: begin
        if (!field_ok) state_next = S_IDLE;
        else if (take_pair) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_SEEK;
      end
      S_SEEK: begin
        if (!field_ok || take_pair) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = more ? S_READ : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      bits_per_prob      <= gpdu_pkg::BITS_PER_PROB_RST;
      phased_mode        <= 1'b0;
      sample_count       <= gpdu_pkg::SAMPLE_COUNT_RST;
      status_write_index <= '0;
      acc                <= '0;
      acc_bits           <= '0;
      first_held         <= '0;
      have_first         <= 1'b0;
      next_sample        <= '0;
      more               <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      state <= state_next;

      unique case (state) inside
        S_IDLE: begin
          if (in_accept) begin
            if (in_action == gpdu_pkg::ACT_STATUS) begin
              status_write_index <= st_wr_en ? swi_eff + 1'b1 : swi_eff;
            end else if (in_restart) begin
              acc         <= gpdu_pkg::ACC_W'(in_byte);
              acc_bits    <= gpdu_pkg::BITS_W'(8);
              first_held  <= '0;
              have_first  <= 1'b0;
              next_sample <= '0;
            end else begin
              acc      <= acc | (gpdu_pkg::ACC_W'(in_byte) << acc_bits);
              acc_bits <= acc_bits + gpdu_pkg::BITS_W'(8);
            end
          end
        end
        S_EXTRACT, S_SEEK: begin
          if (field_ok) begin
            acc      <= acc >> eff_b;
            acc_bits <= acc_bits - eff_b;
            if (!have_first) begin
              first_held <= field;
              have_first <= 1'b1;
            end else begin
              have_first <= 1'b0;
              if (pair_ok) next_sample <= next_sample + 1'b1;
            end
          end
          more <= take_pair;
        end
        default: ;
      endcase

      // output register
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // register writes (the user must write only while the block is idle; the block does not enforce it)
      if (cfg_wr) begin
        unique case (cfg_idx)
          gpdu_pkg::REG_BITS_PER_PROB: begin
            bits_per_prob <= pwdata[gpdu_pkg::BITS_W-1:0];
            acc           <= '0;
            acc_bits      <= '0;
            first_held    <= '0;
            have_first    <= 1'b0;
          end
          gpdu_pkg::REG_PHASED_MODE:  phased_mode  <= pwdata[0];
          gpdu_pkg::REG_SAMPLE_COUNT: sample_count <= pwdata[gpdu_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == S_EXTRACT || state == S_SEEK) && take_pair) begin
      r0       <= first_held;
      r1       <= field;
      pair_idx <= next_sample;
    end
    if (state == S_READ) begin
      st_q <= rd_data;
    end
    if (state == S_DIV && div_done) begin
      res_idx  <= gpdu_pkg::IDX_W'(pair_idx);
      res_dos  <= st_q[0] ? '0 : dosage_val;
      res_miss <= st_q[0];
      res_bad  <= st_q[1];
    end
    if (state == S_EMIT && out_free) begin
      m_tdata <= {7'b0, res_bad, res_miss, res_dos, res_idx};
      m_tlast <= ~more;
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      gpdu_pkg::REG_BITS_PER_PROB: prdata = gpdu_pkg::PDATA_W'(bits_per_prob);
      gpdu_pkg::REG_PHASED_MODE:   prdata = gpdu_pkg::PDATA_W'(phased_mode);
      gpdu_pkg::REG_SAMPLE_COUNT:  prdata = gpdu_pkg::PDATA_W'(sample_count);
      default:                     prdata = '0;
    endcase
  end

  // Checks
  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (acc_bits < eff_b))
    else $error("idle with a whole field still in the accumulator");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc_bits <= gpdu_pkg::BITS_W'(gpdu_pkg::ACC_W - 1))
    else $error("accumulator bit count overflow");

  a_read_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ($past(rd_addr) == pair_idx[AW-1:0]))
    else $error("status read issued for the wrong sample");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> m_tvalid)
    else $error("result not presented after emit");

endmodule

`default_nettype wire

// File: tb/dosage_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and register channels, tracks the decoder state
// and compares every result beat with the oldest predicted one.
module dosage_checker
  import gpdu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte, [8] restart
  input  logic [0:0]             s_tuser,   // [0] action
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] sample_index, [30:12] dosage,
                                            // [31] missing, [32] bad_ploidy
  input  logic                   m_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  input  logic [PDATA_W-1:0]     prdata,
  input  logic                   pready,
  output int                     errors,
  output int                     pending,
  output int                     results_seen
);

  localparam int FRAC       = FRACTION_BITS_DEF;
  localparam int NSAMP      = MAX_SAMPLES_DEF;
  localparam int DOSAGE_LSB = IDX_W;
  localparam int MISS_POS   = IDX_W + DOSAGE_W;
  localparam int BAD_POS    = MISS_POS + 1;
  localparam int MAX_PER_BYTE = 4;

  typedef struct packed {
    logic [IDX_W-1:0]    sample_index;
    logic [DOSAGE_W-1:0] dosage;
    logic                missing;
    logic                bad_ploidy;
    logic                last;
  } dosage_beat_t;

  dosage_beat_t expected_dosages[$];

  // register copies
  logic [BITS_W-1:0]  bits_per_prob;
  logic               phased_mode;
  logic [COUNT_W-1:0] sample_count;

  // decoder state
  logic [1:0]  status_mem [NSAMP];
  int unsigned status_wr;
  logic [63:0] bit_acc;
  int unsigned acc_bits;
  logic [31:0] held_field;
  logic        have_held;
  int unsigned next_sample;

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    for (int i = 0; i < NSAMP; i++) status_mem[i] = 2'b00;
  end

  function automatic void clear_unpacker();
    bit_acc = '0;
    acc_bits = 0;
    held_field = '0;
    have_held = 1'b0;
  endfunction

  // 2 - num/D in fixed point, rounded to nearest; D odd so no ties
  function automatic logic [DOSAGE_W-1:0] calc_dosage(logic [31:0] r0, logic [31:0] r1,
                                                      int unsigned w, logic ph);
    logic [63:0] d, num, q, v;
    d = (64'd1 << w) - 64'd1;
    num = ph ? ({32'd0, r0} + {32'd0, r1}) : (({32'd0, r0} << 1) + {32'd0, r1});
    q = ((num << (FRAC + 1)) + d) / (d << 1);
    v = (64'd1 << (FRAC + 1)) - q;
    return v[DOSAGE_W-1:0];
  endfunction

  // Unpack one bitstream byte and queue the dosages it completes
  task automatic take_prob_byte(logic [7:0] b, logic rs);
    int unsigned w, lim, n;
    logic [63:0] mask;
    logic [31:0] field;
    logic [1:0] st;
    dosage_beat_t beats [MAX_PER_BYTE];
    if (rs) begin
      clear_unpacker();
      next_sample = 0;
    end
    w = (bits_per_prob == 0) ? 1 : ((bits_per_prob > 32) ? 32 : int'(bits_per_prob));
    mask = (64'd1 << w) - 64'd1;
    lim = (sample_count < NSAMP) ? int'(sample_count) : NSAMP;
    n = 0;
    bit_acc = bit_acc | (64'(b) << acc_bits);
    acc_bits += 8;
    while (acc_bits >= w) begin
      field = bit_acc[31:0] & mask[31:0];
      bit_acc = bit_acc >> w;
      acc_bits -= w;
      if (!have_held) begin
        held_field = field;
        have_held = 1'b1;
      end else begin
        have_held = 1'b0;
        if (next_sample < lim && n < MAX_PER_BYTE) begin
          st = status_mem[next_sample];
          beats[n].sample_index = next_sample[IDX_W-1:0];
          beats[n].missing = st[0];
          beats[n].bad_ploidy = st[1];
          beats[n].dosage = st[0] ? '0 : calc_dosage(held_field, field, w, phased_mode);
          beats[n].last = 1'b0;
          n++;
          next_sample++;
        end
      end
    end
    for (int i = 0; i < int'(n); i++) begin
      if (i == int'(n) - 1) beats[i].last = 1'b1;
      expected_dosages.push_back(beats[i]);
    end
  endtask

  always @(posedge clk) begin
    logic [PDATA_W-1:0] reg_val;
    dosage_beat_t got, exp_beat;
    if (rst) begin
      bits_per_prob = BITS_PER_PROB_RST;
      phased_mode = 1'b0;
      sample_count = SAMPLE_COUNT_RST;
      status_wr = 0;
      next_sample = 0;
      clear_unpacker();
      expected_dosages.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_BITS_PER_PROB: begin
              bits_per_prob = pwdata[BITS_W-1:0];
              clear_unpacker();
            end
            REG_PHASED_MODE:  phased_mode = pwdata[0];
            REG_SAMPLE_COUNT: sample_count = pwdata[COUNT_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_BITS_PER_PROB: reg_val = PDATA_W'(bits_per_prob);
            REG_PHASED_MODE:   reg_val = PDATA_W'(phased_mode);
            REG_SAMPLE_COUNT:  reg_val = PDATA_W'(sample_count);
            default:           reg_val = prdata;
          endcase
          if (prdata !== reg_val) begin
            $display("%0t: register %0d read mismatch: expected 0x%0h, got 0x%0h",
                     $time, paddr[3:2], reg_val, prdata);
            errors++;
          end
        end
      end

      // input beat
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == ACT_STATUS) begin
          if (s_tdata[8]) status_wr = 0;
          if (status_wr < NSAMP) begin
            status_mem[status_wr] = {s_tdata[5:0] != PLOIDY_DIPLOID, s_tdata[MISSING_BIT]};
            status_wr++;
          end
        end else begin
          take_prob_byte(s_tdata[7:0], s_tdata[8]);
        end
      end

      // result beat
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.sample_index = m_tdata[IDX_W-1:0];
        got.dosage = m_tdata[DOSAGE_LSB +: DOSAGE_W];
        got.missing = m_tdata[MISS_POS];
        got.bad_ploidy = m_tdata[BAD_POS];
        got.last = m_tlast;
        if (expected_dosages.size() == 0) begin
          $display("%0t: unexpected result: expected none, got idx=%0d dosage=%0d miss=%0b bad=%0b last=%0b",
                   $time, got.sample_index, $signed(got.dosage), got.missing,
                   got.bad_ploidy, got.last);
          errors++;
        end else begin
          exp_beat = expected_dosages.pop_front();
          if (got !== exp_beat) begin
            $display("%0t: result mismatch: expected idx=%0d dosage=%0d miss=%0b bad=%0b last=%0b",
                     $time, exp_beat.sample_index, $signed(exp_beat.dosage),
                     exp_beat.missing, exp_beat.bad_ploidy, exp_beat.last);
            $display("%0t:                  got      idx=%0d dosage=%0d miss=%0b bad=%0b last=%0b",
                     $time, got.sample_index, $signed(got.dosage), got.missing,
                     got.bad_ploidy, got.last);
            errors++;
          end
        end
      end
    end
    pending = expected_dosages.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gpdu_pkg::*;

  localparam int MAX_GAP      = 12;
  localparam int HOLD_OFF     = 300;   // long receiver stall for back-pressure
  localparam int SETTLE       = 200;   // covers a byte's worst latency
  localparam int STALL_LIMIT  = 5000;  // cycles without any channel activity
  localparam int RANDOM_ITEMS = 430;
  localparam int NSAMP        = MAX_SAMPLES_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte, [8] restart
  logic [0:0]             s_tuser = '0;   // [0] action
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [11:0] sample_index, [30:12] dosage,
                                          // [31] missing, [32] bad_ploidy
  logic                   m_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  int chk_errors, chk_pending, chk_results;
  int tx_gap_max = MAX_GAP;
  int rx_stall_max = MAX_GAP;
  bit hold_off_req = 1'b0;
  int items_sent = 0;
  int phases_run = 0;
  int quiet = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  genotype_probability_dosage_unpack dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dosage_checker dosage_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(chk_errors), .pending(chk_pending), .results_seen(chk_results)
  );

  // Watchdog: no beat and no register access for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("%0t: no channel activity for %0d cycles", $time, STALL_LIMIT);
      $display("genotype_probability_dosage_unpack test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    bit got;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = m_tvalid;
        @(posedge clk);
      end while (!got);
    end
  end

  // One input beat; called at a rising edge, returns at the accepting edge
  task automatic send_beat(logic act, logic [7:0] b, logic rs);
    int gap;
    bit ok;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {7'd0, rs, b};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    items_sent++;
  endtask

  task automatic s_idle();
    s_tvalid <= 1'b0;
  endtask

  // Back-to-back accesses keep psel high; read_back drops it
  task automatic reg_access(logic wr, logic [1:0] idx, logic [PDATA_W-1:0] val);
    bit ok;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic read_back();
    reg_access(1'b0, REG_BITS_PER_PROB, '0);
    reg_access(1'b0, REG_PHASED_MODE, '0);
    reg_access(1'b0, REG_SAMPLE_COUNT, '0);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every predicted result is out and the block has gone quiet
  task automatic settle();
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic begin_phase(int bpp, int ph, int cnt);
    settle();
    reg_access(1'b1, REG_BITS_PER_PROB, PDATA_W'(bpp));
    reg_access(1'b1, REG_PHASED_MODE, PDATA_W'(ph));
    reg_access(1'b1, REG_SAMPLE_COUNT, PDATA_W'(cnt));
    read_back();
    phases_run++;
  endtask

  // Mostly diploid present samples, some missing, some odd ploidy
  function automatic logic [7:0] pick_status();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = {1'b0, v[6], PLOIDY_DIPLOID};
      6:                v = {1'b1, v[6], PLOIDY_DIPLOID};
      7:                v = {2'b00, v[5:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_prob();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int bpp, ph, cnt, weff, nres, nstat, nprob, sel, random_start;
    bit rs_first;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of the registers
    read_back();

    // fill the whole status store and run past its depth
    for (int i = 0; i < NSAMP + 4; i++) send_beat(ACT_STATUS, pick_status(), i == 0);
    s_idle();

    // B=8 unphased: full-range pairs, missing and odd-ploidy samples, pair past count
    begin_phase(8, 0, 4);
    send_beat(ACT_STATUS, 8'h02, 1'b1);
    send_beat(ACT_STATUS, 8'h82, 1'b0);
    send_beat(ACT_STATUS, 8'h01, 1'b0);
    send_beat(ACT_STATUS, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b1);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'h12, 1'b0);
    send_beat(ACT_PROB, 8'h34, 1'b0);
    s_idle();

    // B=1 phased: four results per byte, then bytes past the count
    begin_phase(1, 1, 8);
    send_beat(ACT_PROB, 8'hFF, 1'b1);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'hA5, 1'b0);
    s_idle();

    // width above 32 acts as 32; count above the store depth
    begin_phase(63, 0, 8191);
    send_beat(ACT_PROB, 8'hFF, 1'b1);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'hFF, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    send_beat(ACT_PROB, 8'h00, 1'b0);
    s_idle();

    // width 0 acts as 1; count 0 gives nothing
    begin_phase(0, 1, 0);
    send_beat(ACT_PROB, 8'h5A, 1'b0);
    s_idle();

    // back-pressure: receiver holds off while the sender keeps offering beats
    begin_phase(1, 0, 4096);
    tx_gap_max = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_beat(ACT_PROB, pick_prob(), i == 0);
    s_idle();
    tx_gap_max = MAX_GAP;

    // random phases
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0)     bpp = 0;
      else if (sel == 1) bpp = $urandom_range(33, 63);
      else if (sel < 5) bpp = $urandom_range(17, 32);
      else              bpp = $urandom_range(1, 16);
      weff = (bpp == 0) ? 1 : ((bpp > 32) ? 32 : bpp);
      ph = $urandom_range(0, 1);
      sel = $urandom_range(0, 19);
      if (sel == 0)      cnt = 0;
      else if (sel == 1) cnt = 4096;
      else if (sel == 2) cnt = 8191;
      else               cnt = $urandom_range(1, 12);
      nstat = (cnt <= 12) ? cnt + $urandom_range(0, 2) : $urandom_range(1, 12);
      nres = (weff <= 16) ? $urandom_range(1, 8) : $urandom_range(1, 2);
      nprob = (nres * 2 * weff + 7) / 8 + $urandom_range(0, 2);
      rs_first = ($urandom_range(0, 4) != 0);
      // some phases run with no idling on either side
      if ($urandom_range(0, 4) == 0) begin
        tx_gap_max = 0;
        rx_stall_max = 0;
      end else begin
        tx_gap_max = MAX_GAP;
        rx_stall_max = MAX_GAP;
      end

      begin_phase(bpp, ph, cnt);
      for (int i = 0; i < nstat; i++) send_beat(ACT_STATUS, pick_status(), i == 0);
      for (int i = 0; i < nprob; i++) begin
        sel = $urandom_range(0, 19);
        // occasional stray status beat or mid-stream restart
        if (sel == 0) send_beat(ACT_STATUS, pick_status(), 1'b0);
        else send_beat(ACT_PROB, pick_prob(), (i == 0 && rs_first) || sel == 1);
      end
      s_idle();
    end

    settle();
    $display("Covered %0d input beats over %0d register settings, %0d dosage results checked,",
             items_sent, phases_run, chk_results);
    $display("including widths 0, 1, 32 and above, both formulas, counts 0 to 8191.");
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("genotype_probability_dosage_unpack test passed");
    end else begin
      $display("genotype_probability_dosage_unpack test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/gpdu_pkg.sv
sv/gpdu_div.sv
sv/genotype_probability_dosage_unpack.sv
tb/dosage_checker.sv
tb/tb.sv
